@@ src/mdc_pkg.sv @@
// ----------------------------------------------------------------------------
// Determinant unit package
// Shared types and constants for the cofactor determinant unit.
// ----------------------------------------------------------------------------
package mdc_pkg;

    localparam int MAX_DIM     = 4;
    localparam int STORE_DEPTH = MAX_DIM * MAX_DIM;
    localparam int ADDR_W      = $clog2(STORE_DEPTH);
    localparam int PERM_CNT    = 24;
    localparam int PERM_W      = 5;
    localparam int ACC_W       = 72;

    typedef logic signed [15:0] t_elem;

    // Controller to datapath commands.
    typedef struct packed {
        logic       store;     // write incoming element
        logic       clear;     // clear accumulator
        logic       term;      // add one permutation term
        logic       finish;    // saturate and present result
        logic [2:0] size;      // effective matrix size
        logic [PERM_W-1:0] perm;
        logic [ADDR_W-1:0] addr;  // store address of the incoming element
    } t_cmd;

    // Permutation table for 4x4 (rows 0..3 chosen per column) and its sign.
    // Entries are packed as four 2-bit row indexes, column 0 in the low bits.
    // The first two entries fix rows 2 and 3, and the first six fix row 3, so
    // a smaller matrix uses a prefix of the table.
    function automatic logic [8:0] perm_entry(input logic [PERM_W-1:0] idx);
        logic [8:0] r;
        case (idx)
            5'd0:  r = {1'b0, 2'd3, 2'd2, 2'd1, 2'd0};
            5'd1:  r = {1'b1, 2'd3, 2'd2, 2'd0, 2'd1};
            5'd2:  r = {1'b1, 2'd3, 2'd1, 2'd2, 2'd0};
            5'd3:  r = {1'b0, 2'd3, 2'd1, 2'd0, 2'd2};
            5'd4:  r = {1'b0, 2'd3, 2'd0, 2'd2, 2'd1};
            5'd5:  r = {1'b1, 2'd3, 2'd0, 2'd1, 2'd2};
            5'd6:  r = {1'b1, 2'd2, 2'd3, 2'd1, 2'd0};
            5'd7:  r = {1'b0, 2'd2, 2'd3, 2'd0, 2'd1};
            5'd8:  r = {1'b0, 2'd2, 2'd1, 2'd3, 2'd0};
            5'd9:  r = {1'b1, 2'd2, 2'd1, 2'd0, 2'd3};
            5'd10: r = {1'b1, 2'd2, 2'd0, 2'd3, 2'd1};
            5'd11: r = {1'b0, 2'd2, 2'd0, 2'd1, 2'd3};
            5'd12: r = {1'b0, 2'd1, 2'd3, 2'd2, 2'd0};
            5'd13: r = {1'b1, 2'd1, 2'd3, 2'd0, 2'd2};
            5'd14: r = {1'b1, 2'd1, 2'd2, 2'd3, 2'd0};
            5'd15: r = {1'b0, 2'd1, 2'd2, 2'd0, 2'd3};
            5'd16: r = {1'b0, 2'd1, 2'd0, 2'd3, 2'd2};
            5'd17: r = {1'b1, 2'd1, 2'd0, 2'd2, 2'd3};
            5'd18: r = {1'b1, 2'd0, 2'd3, 2'd2, 2'd1};
            5'd19: r = {1'b0, 2'd0, 2'd3, 2'd1, 2'd2};
            5'd20: r = {1'b0, 2'd0, 2'd2, 2'd3, 2'd1};
            5'd21: r = {1'b1, 2'd0, 2'd2, 2'd1, 2'd3};
            5'd22: r = {1'b1, 2'd0, 2'd1, 2'd3, 2'd2};
            5'd23: r = {1'b0, 2'd0, 2'd1, 2'd2, 2'd3};
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

@@ src/mdc_ctrl.sv @@
// ----------------------------------------------------------------------------
// Determinant unit controller
// Counts loaded elements and steps through the permutation terms.
// ----------------------------------------------------------------------------
module mdc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic          i_cfg_we,
    input  logic [2:0]    i_cfg_size,
    output logic          o_busy,
    output mdc_pkg::t_cmd o_cmd
);
    import mdc_pkg::*;

    typedef enum logic [1:0] {S_LOAD, S_CALC, S_DONE} t_state;

    t_state            r_state, n_state;
    logic [2:0]        r_size;
    logic [4:0]        r_count, n_count;
    logic [PERM_W-1:0] r_perm, n_perm;
    logic [2:0]        eff;
    logic [4:0]        total;
    logic [PERM_W-1:0] last_perm;

    always_comb begin
        if (r_size == 3'd0) begin
            eff = 3'd1;
        end else if (r_size > 3'(MAX_DIM)) begin
            eff = 3'(MAX_DIM);
        end else begin
            eff = r_size;
        end
        total = 5'(eff * eff);
        // Permutations of the rows in use: those that fix the unused rows are
        // the first n! entries of the table.
        unique case (eff)
            3'd1:    last_perm = 5'd0;
            3'd2:    last_perm = 5'd1;
            3'd3:    last_perm = 5'd5;
            default: last_perm = 5'(PERM_CNT - 1);
        endcase
    end

    always_comb begin
        n_state = r_state;
        n_count = r_count;
        n_perm  = r_perm;
        o_cmd   = '0;
        o_cmd.size = eff;
        o_cmd.perm = r_perm;
        o_cmd.addr = r_count[ADDR_W-1:0];
        unique case (r_state)
            S_LOAD: begin
                if (i_start) begin
                    o_cmd.store = 1'b1;
                    if (r_count + 5'd1 >= total) begin
                        n_count = '0;
                        n_perm  = '0;
                        n_state = S_CALC;
                        o_cmd.clear = 1'b1;
                    end else begin
                        n_count = r_count + 5'd1;
                    end
                end
            end
            S_CALC: begin
                o_cmd.term = 1'b1;
                if (r_perm == last_perm) begin
                    n_state = S_DONE;
                end else begin
                    n_perm = r_perm + 5'd1;
                end
            end
            S_DONE: begin
                o_cmd.finish = 1'b1;
                n_state = S_LOAD;
            end
            default: n_state = S_LOAD;
        endcase
    end

    assign o_busy = (r_state != S_LOAD);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_LOAD;
            r_count <= '0;
            r_perm  <= '0;
            r_size  <= 3'(MAX_DIM);
        end else begin
            r_state <= n_state;
            r_count <= n_count;
            r_perm  <= n_perm;
            if (i_cfg_we) begin
                r_size  <= i_cfg_size;
                r_count <= '0;
            end
        end
    end
endmodule

@@ src/mdc_dpath.sv @@
// ----------------------------------------------------------------------------
// Determinant unit datapath
// Element store, one product term per cycle, accumulator and saturation.
// ----------------------------------------------------------------------------
module mdc_dpath (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  mdc_pkg::t_cmd i_cmd,
    input  logic [15:0]   i_element,
    output logic          o_valid,
    output logic [63:0]   o_determinant,
    output logic          o_overflow
);
    import mdc_pkg::*;

    t_elem                   r_mem [STORE_DEPTH];
    logic signed [ACC_W-1:0] r_acc;
    logic signed [31:0]      r_p01, r_p23;
    logic                    r_p_vld, r_p_sgn;
    logic signed [ACC_W-1:0] r_term;
    logic                    r_t_vld, r_t_sgn;
    logic [63:0]             r_det;
    logic                    r_ovf;

    logic [8:0]              pe;
    t_elem                   e [MAX_DIM];
    logic [2:0]              n;

    // Entry (row, col) of an n x n matrix sits at row*n+col; a column that is
    // not in use contributes a factor of one.
    always_comb begin
        pe = perm_entry(i_cmd.perm);
        n  = i_cmd.size;
        for (int c = 0; c < MAX_DIM; c++) begin
            if (3'(c) < n) begin
                e[c] = r_mem[ADDR_W'(pe[2*c +: 2] * n + 3'(c))];
            end else begin
                e[c] = 16'sd1;
            end
        end
    end

    // The sign flag travels with its product through both stages.
    always_ff @(posedge i_clk) begin
        if (i_cmd.store) begin
            r_mem[i_cmd.addr] <= i_element;
        end
        r_p01 <= e[0] * e[1];
        r_p23 <= e[2] * e[3];
        r_p_sgn <= pe[8];
        r_term <= ACC_W'(r_p01 * r_p23);
        r_t_sgn <= r_p_sgn;
        if (r_t_vld) begin
            r_acc <= r_t_sgn ? r_acc - r_term : r_acc + r_term;
        end
        if (i_cmd.clear) begin
            r_acc <= '0;
        end
    end

    logic signed [ACC_W-1:0] final_acc;
    assign final_acc = r_acc;

    logic [1:0] r_fin;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_vld <= 1'b0;
            r_t_vld <= 1'b0;
            r_fin   <= '0;
            o_valid <= 1'b0;
        end else begin
            r_p_vld <= i_cmd.term;
            r_t_vld <= r_p_vld;
            r_fin   <= {r_fin[0], i_cmd.finish};
            o_valid <= r_fin[1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (final_acc > 72'sh007FFFFFFFFFFFFFFF) begin
            r_det <= 64'h7FFF_FFFF_FFFF_FFFF;
            r_ovf <= 1'b1;
        end else if (final_acc < -72'sh008000000000000000) begin
            r_det <= 64'h8000_0000_0000_0000;
            r_ovf <= 1'b1;
        end else begin
            r_det <= final_acc[63:0];
            r_ovf <= 1'b0;
        end
    end

    assign o_determinant = r_det;
    assign o_overflow    = r_ovf;
endmodule

@@ src/matrix_determinant_cofactor_unit.sv @@
// After the last element of an n x n matrix is accepted, the controller sweeps
// the n! permutation terms (1, 2, 6 or 24); the sum then passes the product,
// accumulate and saturate stages, and the result strobe follows.
// Throughput: one element per cycle while loading; busy is high during the
// term sweep and drain. Reset is synchronous and active low; size returns to
// 4 and the load count to zero. Results cannot be held off by the receiver.
// ----------------------------------------------------------------------------
// Cofactor determinant unit
// Loads an n x n matrix one item per cycle while not busy and returns its
// exact determinant, saturated to 64 bits, by summing the signed permutation
// products that the cofactor expansion along the first column produces.
// ----------------------------------------------------------------------------
module matrix_determinant_cofactor_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_wdata,
    input  logic [15:0] i_element,
    output logic        o_valid,
    output logic [63:0] o_determinant,
    output logic        o_overflow
);
    import mdc_pkg::*;

    t_cmd cmd;
    logic ctl_busy;
    logic [2:0] r_drain;

    // The controller walks the loaded items and the permutation terms; the
    // datapath holds the store, the multiplier pipeline and the accumulator.
    mdc_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (start && !busy),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_size (i_cfg_wdata),
        .o_busy     (ctl_busy),
        .o_cmd      (cmd)
    );

    mdc_dpath u_dpath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .i_element     (i_element),
        .o_valid       (o_valid),
        .o_determinant (o_determinant),
        .o_overflow    (o_overflow)
    );

    // Busy stays high until the result has drained out of the pipeline.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_drain <= '0;
        end else if (cmd.finish) begin
            r_drain <= 3'd3;
        end else if (r_drain != 3'd0) begin
            r_drain <= r_drain - 3'd1;
        end
    end

    assign busy = ctl_busy || (r_drain != 3'd0);
endmodule
